// ===== sv/assert_macros.svh =====
// Assertion macros shared by the duration statistics RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define DSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define DSC_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== sv/dsc_pkg.sv =====
// Package with types and constants for the duration statistics counters.
`default_nettype none

package dsc_pkg;

   // Default table depth
   localparam int NUM_EVENT_IDS_DEFAULT = 8;

   // Operation codes
   localparam logic [1:0] OP_RECORD   = 2'd0;
   localparam logic [1:0] OP_SLOW     = 2'd1;
   localparam logic [1:0] OP_SNAPSHOT = 2'd2;

   // Field widths
   localparam int OP_W    = 2;
   localparam int ID_W    = 3;
   localparam int DUR_W   = 32;
   localparam int COUNT_W = 32;
   localparam int TOTAL_W = 64;
   localparam int MAX_W   = 32;
   localparam int SLOW_W  = 32;

   // Stream data widths, padded to whole bytes
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 168;

   // One statistics entry as stored in the table
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [TOTAL_W-1:0] total;
      logic [MAX_W-1:0]   max;
   } stat_entry_type;

   // Table access controls from the sequencer
   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic rd_clr;
   } mem_ctl_type;

endpackage

`default_nettype wire

// ===== sv/duration_statistics_counters_core.sv =====
// Top level of the duration statistics counters with read-and-clear snapshot.
// Order: a record updates its entry in the cycle after acceptance; the first snapshot
//   result is loaded through the ST_SNAP_RD and ST_SNAP_WR states that follow acceptance.
// Throughput: record and slow-frame requests 1 per cycle while no snapshot runs, set by the pipelined
//   read-modify-write of the table with write forwarding; a snapshot reads then loads
//   each entry in turn and waits out any result stall.
// Reset: synchronous; clears the slow-frame counter, the entry valid bits and the
//   sequencer at once, so the table reads as zero without a clearing pass.
`default_nettype none

module duration_statistics_counters_core #(
   parameter int NUM_EVENT_IDS = dsc_pkg::NUM_EVENT_IDS_DEFAULT
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   // operation[1:0], event_id[4:2], elapsed_us[36:5], zero pad[39:37]
   input  wire [dsc_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   // entry_id[2:0], call_count[34:3], total_us[98:35], max_us[130:99],
   // slow_frame_count[162:131], zero pad[167:163]
   output logic [dsc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);

   localparam int AW = (NUM_EVENT_IDS > 1) ? $clog2(NUM_EVENT_IDS) : 1;
   localparam int XW = (AW > dsc_pkg::ID_W) ? AW : dsc_pkg::ID_W;
   localparam logic [AW-1:0] LAST_IDX = AW'(NUM_EVENT_IDS - 1);

   // Sequencer states
   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_SNAP_RD = 2'd1;
   localparam logic [1:0] ST_SNAP_WR = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [AW-1:0]                 idx_ff, idx_in;
   logic [dsc_pkg::SLOW_W-1:0]    slow_ff, slow_in;
   logic [dsc_pkg::SLOW_W-1:0]    snap_slow_ff, snap_slow_in;
   logic                          s1_valid_ff, s1_valid_in;
   logic [AW-1:0]                 s1_addr_ff, s1_addr_in;
   logic [dsc_pkg::DUR_W-1:0]     s1_dur_ff, s1_dur_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [dsc_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          req_accept;
   logic [dsc_pkg::OP_W-1:0]      req_op;
   logic [dsc_pkg::ID_W-1:0]      req_id;
   logic [dsc_pkg::DUR_W-1:0]     req_dur;
   logic [XW-1:0]                 req_id_ext;
   logic                          id_in_range;
   logic                          rec_go;
   logic                          rsp_free;
   logic [XW-1:0]                 idx_ext;

   dsc_pkg::mem_ctl_type          mem_ctl;
   dsc_pkg::stat_entry_type       mem_wr_data;
   dsc_pkg::stat_entry_type       mem_rd_data;
   logic [AW-1:0]                 mem_rd_addr;

   // Unpack the request
   assign req_op     = req_tdata[1:0];
   assign req_id     = req_tdata[4:2];
   assign req_dur    = req_tdata[36:5];
   assign req_id_ext = XW'(req_id);
   assign id_in_range = (32'(req_id) < 32'(NUM_EVENT_IDS));

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rec_go     = req_accept && (req_op == dsc_pkg::OP_RECORD) && id_in_range;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign idx_ext    = XW'(idx_ff);

   // Table reads: record lookup or snapshot sweep
   always_comb begin
      mem_ctl.rd_en  = rec_go || (state_ff == ST_SNAP_RD);
      mem_ctl.rd_clr = (state_ff == ST_SNAP_RD);
      mem_ctl.wr_en  = s1_valid_ff;
      mem_rd_addr    = (state_ff == ST_SNAP_RD) ? idx_ff : req_id_ext[AW-1:0];
   end

   // Update the entry read in the previous cycle
   always_comb begin
      mem_wr_data.count = mem_rd_data.count + 32'd1;
      mem_wr_data.total = mem_rd_data.total + 64'(s1_dur_ff);
      mem_wr_data.max   = (s1_dur_ff > mem_rd_data.max) ? s1_dur_ff : mem_rd_data.max;
   end

   dsc_stat_mem #(
      .NUM_EVENT_IDS (NUM_EVENT_IDS),
      .AW            (AW)
   ) u_stat_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .wr_addr (s1_addr_ff),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Hold the record in the update stage
   always_comb begin
      s1_valid_in = rec_go;
      s1_addr_in  = rec_go ? req_id_ext[AW-1:0] : s1_addr_ff;
      s1_dur_in   = rec_go ? req_dur : s1_dur_ff;
   end

   // Sequence slow frames, snapshot sweep and result register
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      slow_in      = slow_ff;
      snap_slow_in = snap_slow_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_op == dsc_pkg::OP_SLOW)) begin
               slow_in = slow_ff + 32'd1;
            end else if (req_accept && (req_op == dsc_pkg::OP_SNAPSHOT)) begin
               snap_slow_in = slow_ff;
               slow_in      = '0;
               idx_in       = '0;
               state_in     = ST_SNAP_RD;
            end
         end
         ST_SNAP_RD: begin
            state_in = ST_SNAP_WR;
         end
         ST_SNAP_WR: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, snap_slow_ff, mem_rd_data.max, mem_rd_data.total,
                               mem_rd_data.count, idx_ext[dsc_pkg::ID_W-1:0]};
               rsp_last_in  = (idx_ff == LAST_IDX);
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = AW'(idx_ff + 1'b1);
                  state_in = ST_SNAP_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         slow_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         slow_ff      <= slow_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_slow_ff <= snap_slow_in;
      s1_addr_ff   <= s1_addr_in;
      s1_dur_ff    <= s1_dur_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`include "assert_macros.svh"

   `DSC_ASSERT(a_update_only_idle, clock, reset, s1_valid_ff |-> (state_ff == ST_IDLE), "record update overlaps a snapshot")
   `DSC_ASSERT(a_snap_clears_slow, clock, reset, (req_accept && (req_op == dsc_pkg::OP_SNAPSHOT)) |=> (slow_ff == '0), "slow-frame counter not cleared by snapshot")
   `DSC_ASSERT(a_read_then_load, clock, reset, (state_ff == ST_SNAP_RD) |=> (state_ff == ST_SNAP_WR), "snapshot read not followed by result load")
   `DSC_ASSERT_NEVER(a_no_write_in_sweep, clock, reset, mem_ctl.wr_en && mem_ctl.rd_clr, "table write during snapshot sweep")

endmodule

`default_nettype wire

// ===== sv/dsc_stat_mem.sv =====
// Statistics table: registered-read memory with write forwarding and entry valid bits.
`default_nettype none

module dsc_stat_mem #(
   parameter int NUM_EVENT_IDS = dsc_pkg::NUM_EVENT_IDS_DEFAULT,
   parameter int AW            = (NUM_EVENT_IDS > 1) ? $clog2(NUM_EVENT_IDS) : 1
) (
   input  wire                    clock,
   input  wire                    reset,
   input  dsc_pkg::mem_ctl_type   ctl,
   input  wire [AW-1:0]           wr_addr,
   input  dsc_pkg::stat_entry_type wr_data,
   input  wire [AW-1:0]           rd_addr,
   output dsc_pkg::stat_entry_type rd_data
);

   dsc_pkg::stat_entry_type entry_mem_ff [NUM_EVENT_IDS];
   dsc_pkg::stat_entry_type rd_data_ff;
   logic                    rd_valid_ff;
   logic                    rd_valid_in;
   logic [NUM_EVENT_IDS-1:0] valid_ff;
   logic [NUM_EVENT_IDS-1:0] valid_in;
   logic                    fwd;

   // Pass a same-cycle write straight to the read register
   assign fwd = ctl.wr_en && ctl.rd_en && (wr_addr == rd_addr);

   always_comb begin
      rd_valid_in = fwd | valid_ff[rd_addr];
   end

   // Mark written entries, drop entries read by a snapshot
   always_comb begin
      valid_in = valid_ff;
      if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      if (ctl.rd_en && ctl.rd_clr) begin
         valid_in[rd_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read the table, taking a same-cycle write to the same entry
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= fwd ? wr_data : entry_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctl.rd_en) begin
            rd_valid_ff <= rd_valid_in;
         end
      end
   end

   // Entries never written since reset or the last snapshot read as zero
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire
